// ===== rtl/lgs_pkg.sv =====
`default_nettype none

package lgs_pkg;

  localparam int DIM_W = 7;

  // neighbour counts of the b3/s23 rule
  localparam logic [3:0] NB_KEEP  = 4'd2;
  localparam logic [3:0] NB_BIRTH = 4'd3;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_STEP  = 2'd1,
    OP_READ  = 2'd2
  } lgs_op_t;

  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WRITE,
    S_READ,
    S_SWEEP
  } lgs_state_t;

  function automatic logic lgs_life(input logic alive, input logic [7:0] nb);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + 4'(nb[i]);
    end
    if (alive) begin
      return (n == NB_KEEP) || (n == NB_BIRTH);
    end
    return n == NB_BIRTH;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/lgs_ram.sv =====
`default_nettype none

module lgs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic                                    re,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lgs_row_next.sv =====
`default_nettype none

module lgs_row_next
  import lgs_pkg::*;
#(
  parameter int COLS = 64
) (
  input  wire logic [COLS-1:0] above,
  input  wire logic [COLS-1:0] cur,
  input  wire logic [COLS-1:0] cur_raw,
  input  wire logic [COLS-1:0] below,
  input  wire logic [COLS-1:0] col_mask,
  output logic      [COLS-1:0] nxt
);

  // one dead column padded on each side, lane j sits at j+1
  logic [COLS+1:0] a_x;
  logic [COLS+1:0] c_x;
  logic [COLS+1:0] b_x;

  assign a_x = {1'b0, above, 1'b0};
  assign c_x = {1'b0, cur, 1'b0};
  assign b_x = {1'b0, below, 1'b0};

  always_comb begin
    for (int j = 0; j < COLS; j++) begin
      if (col_mask[j]) begin
        nxt[j] = lgs_life(c_x[j+1], {a_x[j], a_x[j+1], a_x[j+2], c_x[j], c_x[j+2],
                                     b_x[j], b_x[j+1], b_x[j+2]});
      end else begin
        nxt[j] = cur_raw[j];
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/life_grid_generation_step_core.sv =====
`default_nettype none

// Conway life engine (b3/s23) on a grid of up to MAX_ROWS by MAX_COLS cells, of which the
// top-left rows_used by cols_used are live area; edges count as dead, no wraparound. The
// grid lives in one RAM, one row per word, and a generation sweeps it one row per cycle
// through a three-row window, then gives its result beat (rows_used clamped to 1..MAX_ROWS).
// A cell write is a read-modify-write of its row. A write or read outside the live area or
// an unused op does not access the RAM. One item is in work at a time and the next is taken
// once the previous result beat has left. After reset the RAM is swept to all dead, one row
// a cycle, during which no item is taken; register writes are taken at any time, cfg_ready
// is always high.
module life_grid_generation_step_core
  import lgs_pkg::*;
#(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [1:0]       op,
  input  wire logic [5:0]       row,
  input  wire logic [5:0]       col,
  input  wire logic             cell_value,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic                  cell_alive,
  output logic                  op_done,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic             cfg_index,
  input  wire logic [DIM_W-1:0] cfg_data
);

  localparam int RAW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CIW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  lgs_state_t state;
  lgs_state_t state_next;

  logic [DIM_W-1:0] rows_used;
  logic [DIM_W-1:0] cols_used;
  logic [DIM_W-1:0] rows_eff;
  logic [DIM_W-1:0] cols_eff;

  logic [RAW-1:0]   clr_row;
  logic [RAW-1:0]   clr_row_next;
  logic [DIM_W-1:0] dk;
  logic [DIM_W-1:0] dk_next;

  logic [5:0]       row_q;
  logic [5:0]       col_q;
  logic             value_q;

  logic [MAX_COLS-1:0] above;
  logic [MAX_COLS-1:0] cur;
  logic [MAX_COLS-1:0] cur_raw;
  logic [MAX_COLS-1:0] incoming;
  logic [MAX_COLS-1:0] col_mask;
  logic [MAX_COLS-1:0] new_row;

  logic                ram_we;
  logic [RAW-1:0]      ram_waddr;
  logic [MAX_COLS-1:0] ram_wdata;
  logic                ram_re;
  logic [RAW-1:0]      ram_raddr;
  logic [MAX_COLS-1:0] rdata;

  logic in_take;
  logic in_area;
  logic latch;
  logic win_clear;
  logic win_shift;
  logic res_set;
  logic res_alive;
  logic res_done;

  // out-of-range register values clamp to 1..max
  always_comb begin
    if (rows_used == '0) begin
      rows_eff = DIM_W'(1);
    end else if (int'(rows_used) > MAX_ROWS) begin
      rows_eff = DIM_W'(MAX_ROWS);
    end else begin
      rows_eff = rows_used;
    end
    if (cols_used == '0) begin
      cols_eff = DIM_W'(1);
    end else if (int'(cols_used) > MAX_COLS) begin
      cols_eff = DIM_W'(MAX_COLS);
    end else begin
      cols_eff = cols_used;
    end
  end

  always_comb begin
    for (int j = 0; j < MAX_COLS; j++) begin
      col_mask[j] = j < int'(cols_eff);
    end
  end

  assign cfg_ready = 1'b1;
  assign in_stall  = !((state == S_IDLE) && !out_valid);
  assign in_take   = in_valid && !in_stall;
  assign in_area   = ({1'b0, row} < rows_eff) && ({1'b0, col} < cols_eff);

  // the row past the bottom edge reads as dead
  assign incoming = (dk < rows_eff) ? (rdata & col_mask) : '0;

  lgs_ram #(
    .WIDTH (MAX_COLS),
    .DEPTH (MAX_ROWS)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  lgs_row_next #(
    .COLS (MAX_COLS)
  ) u_row_next (
    .above    (above),
    .cur      (cur),
    .cur_raw  (cur_raw),
    .below    (incoming),
    .col_mask (col_mask),
    .nxt      (new_row)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    clr_row_next = clr_row;
    dk_next      = dk;
    ram_we       = 1'b0;
    ram_waddr    = RAW'(row_q);
    ram_wdata    = rdata;
    ram_re       = 1'b0;
    ram_raddr    = RAW'(row);
    latch        = 1'b0;
    win_clear    = 1'b0;
    win_shift    = 1'b0;
    res_set      = 1'b0;
    res_alive    = 1'b0;
    res_done     = 1'b1;
    unique case (state)
      S_CLEAR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_row;
        ram_wdata    = '0;
        clr_row_next = clr_row + RAW'(1);
        if (clr_row == RAW'(MAX_ROWS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_take) begin
          latch = 1'b1;
          case (lgs_op_t'(op))
            OP_WRITE: begin
              if (in_area) begin
                ram_re     = 1'b1;
                state_next = S_WRITE;
              end else begin
                res_set = 1'b1;
              end
            end
            OP_READ: begin
              if (in_area) begin
                ram_re     = 1'b1;
                state_next = S_READ;
              end else begin
                res_set = 1'b1;
              end
            end
            OP_STEP: begin
              ram_re     = 1'b1;
              ram_raddr  = '0;
              dk_next    = '0;
              win_clear  = 1'b1;
              state_next = S_SWEEP;
            end
            default: begin
              res_set  = 1'b1;
              res_done = 1'b0;
            end
          endcase
        end
      end
      S_WRITE: begin
        ram_we                  = 1'b1;
        ram_wdata               = rdata;
        ram_wdata[CIW'(col_q)]  = value_q;
        res_set                 = 1'b1;
        state_next              = S_IDLE;
      end
      S_READ: begin
        res_set    = 1'b1;
        res_alive  = rdata[CIW'(col_q)];
        state_next = S_IDLE;
      end
      S_SWEEP: begin
        // data of row dk arrives now; row dk-1 is finished and written back
        win_shift = 1'b1;
        ram_wdata = new_row;
        ram_waddr = RAW'(dk - DIM_W'(1));
        ram_we    = dk != '0;
        if (dk == rows_eff) begin
          res_set    = 1'b1;
          state_next = S_IDLE;
        end else begin
          dk_next   = dk + DIM_W'(1);
          ram_raddr = RAW'(dk + DIM_W'(1));
          ram_re    = (dk + DIM_W'(1)) < rows_eff;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_used <= DIM_W'(64);
      cols_used <= DIM_W'(64);
      clr_row   <= '0;
      dk        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_ROWS: rows_used <= cfg_data;
          REG_COLS: cols_used <= cfg_data;
          default:  rows_used <= cfg_data;
        endcase
      end
      clr_row <= clr_row_next;
      dk      <= dk_next;
      if (res_set) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (latch) begin
      row_q   <= row;
      col_q   <= col;
      value_q <= cell_value;
    end
    if (win_clear) begin
      above   <= '0;
      cur     <= '0;
      cur_raw <= '0;
    end else if (win_shift) begin
      above   <= cur;
      cur     <= incoming;
      cur_raw <= rdata;
    end
    if (res_set) begin
      cell_alive <= res_alive;
      op_done    <= res_done;
    end
  end

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state != S_IDLE) && (state != S_READ))
    else $error("grid ram written outside a write, sweep or clear");

  a_clear_once: assert property (@(posedge clk) disable iff (rst)
    (state != S_CLEAR) |=> (state != S_CLEAR))
    else $error("clearing pass re-entered without reset");

  a_no_result_overrun: assert property (@(posedge clk) disable iff (rst)
    res_set |-> !out_valid)
    else $error("result produced while previous beat still held");

  a_invalid_op_dead: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !op_done) |-> !cell_alive)
    else $error("unused op reported a live cell");

endmodule

`default_nettype wire
